// ===== rtl/core/raid6_pq_parity_accumulator_unit_defines.svh =====
// Assertion macros shared by the P/Q parity accumulator checkers.
// Depends on nothing; the user supplies clk and arst_n in its own scope.
`ifndef RAID6_PQ_PARITY_ACCUMULATOR_UNIT_DEFINES_SVH
`define RAID6_PQ_PARITY_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define RPQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("raid6pq assertion failed");

// Next-cycle implication, sampled on clk, quiet while in reset.
`define RPQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("raid6pq assertion failed");

`endif

// ===== rtl/core/raid6pq_pkg.sv =====
// Package for the RAID-6 P/Q parity accumulator: sizes, command codes,
// word types and the GF(2^8) multiply helper. Depends on nothing.
package raid6pq_pkg;

	localparam int unsigned STRIP_WORDS = 1024;
	localparam int unsigned ADDR_W      = (STRIP_WORDS > 1) ? $clog2(STRIP_WORDS) : 1;
	localparam logic [7:0]  GF_REDUCE   = 8'h1D;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACCUM = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [9:0]  word_index;
		logic [31:0] data_word;
		logic [7:0]  coefficient;
		logic        fold_p;
		logic        fold_q;
	} in_word_t;

	typedef struct packed {
		logic [31:0] p_word;
		logic [31:0] q_word;
	} out_word_t;

	// Shift-and-add product over GF(2^8) with polynomial 0x11D.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ((x << 1) ^ GF_REDUCE) : (x << 1);
		end
		return acc;
	endfunction

endpackage

// ===== rtl/core/raid6pq_in_if.sv =====
// Input channel of the P/Q parity accumulator: valid, ready and one input word.
// Depends on raid6pq_pkg.
interface raid6pq_in_if;
	logic                 valid;
	logic                 ready;
	raid6pq_pkg::in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/raid6pq_out_if.sv =====
// Result channel of the P/Q parity accumulator: valid, ready and one result word.
// Depends on raid6pq_pkg.
interface raid6pq_out_if;
	logic                  valid;
	logic                  ready;
	raid6pq_pkg::out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/raid6pq_gf_mul.sv =====
// Bytewise GF(2^8) multiply of a 32-bit word by one coefficient.
// Depends on raid6pq_pkg for the byte multiply function.
module raid6pq_gf_mul (
	input  logic [31:0] data_word,
	input  logic [7:0]  coefficient,
	output logic [31:0] product
);

	always_comb begin
		for (int lane = 0; lane < 4; lane++) begin
			product[8*lane +: 8] = raid6pq_pkg::gf_mul(data_word[8*lane +: 8], coefficient);
		end
	end

endmodule

// ===== rtl/core/raid6pq_store.sv =====
// P and Q strip memories with registered reads and a write bypass.
// Depends on raid6pq_pkg for the strip depth.
module raid6pq_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [raid6pq_pkg::ADDR_W-1:0] rd_addr,
	input  logic                           wr_en,
	input  logic [raid6pq_pkg::ADDR_W-1:0] wr_addr,
	input  logic [31:0]                    wr_p,
	input  logic [31:0]                    wr_q,
	output logic [31:0]                    rd_p,
	output logic [31:0]                    rd_q
);

	logic [31:0] p_mem [raid6pq_pkg::STRIP_WORDS];
	logic [31:0] q_mem [raid6pq_pkg::STRIP_WORDS];

	logic [31:0] mem_p_q;
	logic [31:0] mem_q_q;
	logic [31:0] byp_p_q;
	logic [31:0] byp_q_q;
	logic        hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			p_mem[wr_addr] <= wr_p;
			q_mem[wr_addr] <= wr_q;
		end
		if (rd_en) begin
			mem_p_q <= p_mem[rd_addr];
			mem_q_q <= q_mem[rd_addr];
			byp_p_q <= wr_p;
			byp_q_q <= wr_q;
		end
	end

	// A read that meets a write to the same word at the same edge sees the old
	// contents, so the written word is kept and returned in its place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_p = hit_q ? byp_p_q : mem_p_q;
	assign rd_q = hit_q ? byp_q_q : mem_q_q;

endmodule

// ===== rtl/core/raid6_pq_parity_accumulator_unit.sv =====
// RAID-6 P/Q parity accumulator: read-modify-write over two strip memories.
// Pipeline: an accepted word is registered into stage one with its memory read,
// then its result is registered into the result register, where it is taken.
// Throughput: one word per cycle while no finished result waits untaken, also to
// the same position back to back, set by the single read and write port of each memory.
// Reset clears the pipeline and result valid flags; memory contents stay
// undefined until each position is cleared or written.
module raid6_pq_parity_accumulator_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	raid6pq_in_if.sink           item,
	raid6pq_out_if.source        result
);

	logic                           adv;
	logic                           accept;
	logic [31:0]                    gf_word;
	logic [31:0]                    rd_p;
	logic [31:0]                    rd_q;
	logic [31:0]                    new_p;
	logic [31:0]                    new_q;
	logic                           wr_en;
	logic                           in_range;

	logic                           vld_s1;
	logic                           clear_s1;
	logic                           range_s1;
	logic [raid6pq_pkg::ADDR_W-1:0] addr_s1;
	logic [31:0]                    fold_p_s1;
	logic [31:0]                    fold_q_s1;

	logic                           res_valid_q;
	raid6pq_pkg::out_word_t         res_q;

	assign adv         = !res_valid_q || result.ready;
	assign item.ready  = adv;
	assign accept      = item.valid && adv;
	assign in_range    = 32'(item.payload.word_index) < raid6pq_pkg::STRIP_WORDS;

	raid6pq_gf_mul u_gf_mul (
		.data_word   (item.payload.data_word),
		.coefficient (item.payload.coefficient),
		.product     (gf_word)
	);

	raid6pq_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (item.payload.word_index[raid6pq_pkg::ADDR_W-1:0]),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_p    (new_p),
		.wr_q    (new_q),
		.rd_p    (rd_p),
		.rd_q    (rd_q)
	);

	// The fold terms are prepared on entry, so stage one only XORs them in.
	always_ff @(posedge clk) begin
		if (accept) begin
			clear_s1  <= item.payload.cmd == raid6pq_pkg::CMD_CLEAR;
			range_s1  <= in_range;
			addr_s1   <= item.payload.word_index[raid6pq_pkg::ADDR_W-1:0];
			fold_p_s1 <= (item.payload.cmd == raid6pq_pkg::CMD_ACCUM && item.payload.fold_p)
				? item.payload.data_word : 32'd0;
			fold_q_s1 <= (item.payload.cmd == raid6pq_pkg::CMD_ACCUM && item.payload.fold_q)
				? gf_word : 32'd0;
		end
	end

	always_comb begin
		new_p = clear_s1 ? 32'd0 : (rd_p ^ fold_p_s1);
		new_q = clear_s1 ? 32'd0 : (rd_q ^ fold_q_s1);
		wr_en = vld_s1 && adv && range_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= item.valid;
			res_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_q.p_word <= range_s1 ? new_p : 32'd0;
			res_q.q_word <= range_s1 ? new_q : 32'd0;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

// ===== rtl/core/raid6pq_checker.sv =====
// Port-level checks for the P/Q parity accumulator, bound to the top level.
// Depends on raid6_pq_parity_accumulator_unit_defines.svh.
`include "raid6_pq_parity_accumulator_unit_defines.svh"

module raid6pq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_p,
	input logic [31:0] result_q
);

	// Input is held back only while a finished word waits to be taken.
	`RPQ_ASSERT_IMP(a_stall_cause, !item_ready, result_valid && !result_ready)

	// A word taken while the result side is empty passes through stage one and then shows as a valid result.
	`RPQ_ASSERT_NXT(a_latency, item_valid && item_ready && !result_valid, ##1 result_valid)

	`RPQ_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid)

	`RPQ_ASSERT_NXT(a_result_stable, result_valid && !result_ready,
		$stable(result_p) && $stable(result_q))

endmodule

bind raid6_pq_parity_accumulator_unit raid6pq_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_p     (result.payload.p_word),
	.result_q     (result.payload.q_word)
);
